>>> hw/rtl/ordered_value_list_defines.svh
// Assertion macros shared by the ordered value list RTL.
// Used by ordered_value_list.sv; depends on nothing else.
`ifndef ORDERED_VALUE_LIST_DEFINES_SVH
`define ORDERED_VALUE_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define OVL_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("ordered_value_list: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define OVL_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ordered_value_list: next-cycle check failed");

`endif

>>> hw/rtl/ovl_pkg.sv
// Shared types and constants of the ordered value list.
// No dependencies; imported by ovl_cell and ordered_value_list.
package ovl_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int VALUE_W          = 32;
   localparam int CMD_W            = 2;
   localparam int POS_W            = 4;

   // Operation codes; the fourth code means nothing and changes nothing.
   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 2'd0,
      CMD_SEARCH = 2'd1,
      CMD_REMOVE = 2'd2
   } cmd_type;

   // Broadcast controls from the sequencer to every cell.
   typedef struct packed {
      logic capture;   // latch the compare result of the incoming request
      logic append;    // the tail cell loads the new value
      logic remove;    // cells at and after the first match take their neighbor's value
   } cell_ctrl_type;

endpackage

>>> hw/rtl/ordered_value_list.sv
// Ordered value list: the request transfer registers the command, the value and
// the cell compare results; the apply step then writes the result register.
// The apply step waits while the consumer still holds off an earlier result.
// A new request is accepted only after the previous one has been applied, set by the
// compare-then-apply sequence through the cell row.
// Reset (synchronous, active high) empties the list and drops any pending result.
// The stored values are not cleared; only cells below the entry count are ever read.
`include "ordered_value_list_defines.svh"

module ordered_value_list
   import ovl_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] value (signed)
   input  logic [1:0]   req_tuser,   // [1:0] cmd
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata    // [0] ok, [4:1] position, [5] is_empty, [7:6] zero
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // The sequencer has two states. In IDLE it takes a request, and on that
   // transfer every cell compares the incoming value with its own entry and
   // keeps the outcome. In APPLY the first match is resolved along the cell
   // chain, the row shifts or loads, and the result is written to the output
   // register. APPLY waits while the output register still holds an untaken
   // result, so a new request is accepted while an older result is pending.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_APPLY = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   cmd_type             cmd_ff, cmd_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                commit;
   logic                found;
   logic                append_ok;
   logic [POS_W-1:0]    first_pos;
   cell_ctrl_type       ctrl;

   logic [CAPACITY-1:0] occupied;
   logic [CAPACITY-1:0] tail;
   logic [CAPACITY-1:0] hit_in;
   logic [CAPACITY-1:0] hit_out;
   logic [CAPACITY-1:0] first;
   logic [VALUE_W-1:0]  cell_value [CAPACITY];
   logic [VALUE_W-1:0]  next_value [CAPACITY];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   // The result register is free, or its result leaves in this cycle.
   assign commit     = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   assign found      = hit_out[CAPACITY-1];
   assign append_ok  = (count_ff < CNT_W'(CAPACITY));

   assign ctrl.capture = req_xfer;
   assign ctrl.append  = commit && (cmd_ff == CMD_APPEND);
   assign ctrl.remove  = commit && (cmd_ff == CMD_REMOVE);

   // The row of cells. Each cell passes the "match seen" flag to its right
   // neighbor and takes its neighbor's value when a removal closes the gap.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occupied[i] = (CNT_W'(i) < count_ff);
      assign tail[i]     = (count_ff == CNT_W'(i));
      if (i == 0) begin : g_head
         assign hit_in[i] = 1'b0;
      end else begin : g_link
         assign hit_in[i] = hit_out[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign next_value[i] = cell_value[i];
      end else begin : g_next
         assign next_value[i] = cell_value[i+1];
      end

      ovl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .occupied   (occupied[i]),
         .tail       (tail[i]),
         .cmp_value  (req_tdata),
         .new_value  (value_ff),
         .next_value (next_value[i]),
         .hit_in     (hit_in[i]),
         .hit_out    (hit_out[i]),
         .first      (first[i]),
         .value_out  (cell_value[i])
      );
   end

   // Binary position of the single first match; positions wrap at 16.
   always_comb begin
      first_pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first[i]) begin
            first_pos = first_pos | POS_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd_in   = cmd_type'(req_tuser);
               value_in = req_tdata;
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (commit) begin
               rsp_data_in = '0;
               case (cmd_ff)
                  CMD_APPEND: begin
                     if (append_ok) begin
                        count_in       = count_ff + CNT_W'(1);
                        rsp_data_in[0] = 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     if (found) begin
                        rsp_data_in[0]   = 1'b1;
                        rsp_data_in[4:1] = first_pos;
                     end
                  end
                  CMD_REMOVE: begin
                     if (found) begin
                        count_in       = count_ff - CNT_W'(1);
                        rsp_data_in[0] = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               rsp_data_in[5] = (count_in == '0);
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      value_ff    <= value_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The entry count never exceeds the number of cells.
   `OVL_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   // The match chain marks at most one first match.
   `OVL_ASSERT_IMPLY(a_single_first, clock, reset, state_ff == ST_APPLY, $onehot0(first))
   // A request transfer always moves the sequencer into the apply step.
   `OVL_ASSERT_NEXT(a_accept_apply, clock, reset, req_xfer, state_ff == ST_APPLY)
   // A successful removal shortens the list by exactly one entry.
   `OVL_ASSERT_NEXT(a_remove_count, clock, reset, ctrl.remove && found,
                    count_ff == $past(count_ff) - CNT_W'(1))

endmodule

>>> hw/rtl/ovl_cell.sv
// One storage cell of the ordered value list: a value, a match flag and
// the link to its neighbors. Depends on ovl_pkg.
module ovl_cell
   import ovl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cell_ctrl_type        ctrl,
   input  logic                 occupied,    // this cell lies below the entry count
   input  logic                 tail,        // this cell is the first free place
   input  logic [VALUE_W-1:0]   cmp_value,   // value of the request being accepted
   input  logic [VALUE_W-1:0]   new_value,   // value of the request in progress
   input  logic [VALUE_W-1:0]   next_value,  // stored value of the following cell
   input  logic                 hit_in,      // a match was found in an earlier cell
   output logic                 hit_out,
   output logic                 first,       // this cell holds the first match
   output logic [VALUE_W-1:0]   value_out
);

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               match_ff, match_in;

   assign match_in  = ctrl.capture ? (occupied && (value_ff == cmp_value)) : match_ff;
   assign hit_out   = hit_in | match_ff;
   assign first     = match_ff & ~hit_in;
   assign value_out = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.append && tail) begin
         value_in = new_value;
      end else if (ctrl.remove && hit_out) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> test/ordered_value_list_tb.sv
// Self-checking testbench for the ordered value list: append, search and remove
// transfers against a shadow list kept inside the bench, with random stalls.
// Depends on ovl_pkg and the ordered_value_list RTL only.
`timescale 1ns / 100ps

module ordered_value_list_tb;
   import ovl_pkg::*;

   localparam int LIST_DEPTH  = DEFAULT_CAPACITY;
   localparam int ITEM_TARGET = 1300;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 10;

   // The fourth operation code has no enum member; it must leave the list alone.
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

   // Random phase modes for the stimulus generator.
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;

   // One request waiting to be sent. A set hold bit makes the driver wait until
   // every earlier result has come back before presenting this request.
   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] value;
      logic               hold;
   } list_request_type;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] position;
      logic             is_empty;
   } list_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;    // [31:0] value (signed)
   logic [1:0]   req_tuser = '0;    // [1:0] cmd
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;         // [0] ok, [4:1] position, [5] is_empty, [7:6] zero

   // Shadow copy of the list as the block should hold it.
   logic [VALUE_W-1:0] list_values [LIST_DEPTH];
   int                 list_count = 0;

   list_request_type pending_requests[$];
   list_result_type  expected_results[$];
   int               request_total = 0;
   int               sent_count = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   // A stretch of the run in which the bench adds no random stalls on either side.
   logic steady;
   assign steady = (sent_count >= 600) && (sent_count < 800);

   ordered_value_list #(
      .CAPACITY(LIST_DEPTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Applies one operation to the shadow list and returns the result the block
   // must report for it. Search and remove both act on the first occurrence;
   // remove shifts later entries down so insertion order is kept.
   function automatic list_result_type apply_list_op(input logic [CMD_W-1:0] op,
                                                     input logic [VALUE_W-1:0] v);
      list_result_type res;
      int              hit;
      res = '0;
      hit = -1;
      if (op == CMD_SEARCH || op == CMD_REMOVE) begin
         for (int i = 0; i < list_count; i++) begin
            if (hit < 0 && list_values[i] == v) hit = i;
         end
      end
      case (op)
         CMD_APPEND: begin
            // A full list refuses the append and stays as it is.
            if (list_count < LIST_DEPTH) begin
               list_values[list_count] = v;
               list_count++;
               res.ok = 1'b1;
            end
         end
         CMD_SEARCH: begin
            if (hit >= 0) begin
               res.ok       = 1'b1;
               res.position = hit[POS_W-1:0];
            end
         end
         CMD_REMOVE: begin
            if (hit >= 0) begin
               for (int i = hit; i + 1 < list_count; i++) list_values[i] = list_values[i + 1];
               list_count--;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.is_empty = (list_count == 0);
      return res;
   endfunction

   task automatic add_request(input logic [CMD_W-1:0] op, input logic [VALUE_W-1:0] v,
                              input logic hold = 1'b0);
      list_request_type item;
      item.cmd   = op;
      item.value = v;
      item.hold  = hold;
      pending_requests.push_back(item);
      request_total++;
   endtask

   // Random part: phases that favor filling, draining or a mix. Values mostly
   // come from a small pool so that searches and removes find their targets and
   // duplicates show up; a few are fully random to toggle every value bit.
   task automatic build_random_requests();
      logic [VALUE_W-1:0] pool [8];
      logic [VALUE_W-1:0] v;
      logic [CMD_W-1:0]   op;
      int                 mode;
      int                 phase_len;
      int                 r;
      int                 phase_index;
      phase_index = 0;
      foreach (pool[k]) pool[k] = $urandom;
      while (request_total < ITEM_TARGET + 25) begin
         mode      = $urandom_range(MODE_FILL, MODE_MIXED);
         phase_len = $urandom_range(8, 40);
         // Refresh one pool entry per phase, sometimes with an extreme value.
         case ($urandom_range(0, 7))
            0:       pool[$urandom_range(0, 7)] = 32'h8000_0000;
            1:       pool[$urandom_range(0, 7)] = 32'h7FFF_FFFF;
            2:       pool[$urandom_range(0, 7)] = 32'hFFFF_FFFF;
            3:       pool[$urandom_range(0, 7)] = 32'h0000_0000;
            default: pool[$urandom_range(0, 7)] = $urandom;
         endcase
         for (int j = 0; j < phase_len; j++) begin
            r  = $urandom_range(0, 99);
            v  = ($urandom_range(0, 9) == 0) ? $urandom : pool[$urandom_range(0, 7)];
            case (mode)
               MODE_FILL:  op = (r < 70) ? CMD_APPEND : (r < 85) ? CMD_SEARCH :
                                (r < 97) ? CMD_REMOVE : CMD_UNKNOWN;
               MODE_DRAIN: op = (r < 15) ? CMD_APPEND : (r < 45) ? CMD_SEARCH :
                                (r < 97) ? CMD_REMOVE : CMD_UNKNOWN;
               default:    op = (r < 35) ? CMD_APPEND : (r < 70) ? CMD_SEARCH :
                                (r < 97) ? CMD_REMOVE : CMD_UNKNOWN;
            endcase
            // Every tenth phase opens with a full drain of the pipeline.
            add_request(op, v, (j == 0) && (phase_index % 10 == 9));
         end
         phase_index++;
      end
   endtask

   // Driver: presents the next pending request when the channel is free, with random gaps.
   // The expected result is worked out at the edge where the transfer happens,
   // so the shadow list follows the block's acceptance order exactly.
   always @(posedge clock) begin
      list_request_type nxt;
      logic             launch;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(apply_list_op(req_tuser, req_tdata));
            sent_count <= sent_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            launch = 1'b0;
            if (pending_requests.size() != 0 && (steady || $urandom_range(0, 99) >= 32)) begin
               launch = !pending_requests[0].hold || (expected_results.size() == 0);
            end
            if (launch) begin
               nxt = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.value;
               req_tuser  <= nxt.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random back-pressure on the result channel and a field-by-field
   // check of every result transfer against the oldest expectation.
   always @(posedge clock) begin
      list_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transfer: tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[0] !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[4:1] !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_tdata[4:1]);
                  error_count++;
               end
               if (rsp_tdata[5] !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_tdata[5]);
                  error_count++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(0, 99) >= 32);
      end
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      // Directed part: empty list, extreme values, duplicates, every operation.
      add_request(CMD_SEARCH,  32'h0000_0000);
      add_request(CMD_REMOVE,  32'h0000_0000);
      add_request(CMD_UNKNOWN, 32'h0000_0000);
      add_request(CMD_APPEND,  32'h8000_0000);
      add_request(CMD_APPEND,  32'h7FFF_FFFF);
      add_request(CMD_APPEND,  32'h0000_0000);
      add_request(CMD_APPEND,  32'hFFFF_FFFF);
      add_request(CMD_APPEND,  32'h7FFF_FFFF);
      // The sender waits here until every earlier result has come back.
      add_request(CMD_SEARCH,  32'h7FFF_FFFF, 1'b1);
      add_request(CMD_SEARCH,  32'hFFFF_FFFF);
      add_request(CMD_SEARCH,  32'h0001_2345);
      add_request(CMD_UNKNOWN, 32'hFFFF_FFFF);
      add_request(CMD_REMOVE,  32'h7FFF_FFFF);
      add_request(CMD_SEARCH,  32'h7FFF_FFFF);
      add_request(CMD_REMOVE,  32'h0001_2345);
      add_request(CMD_REMOVE,  32'h8000_0000);
      add_request(CMD_SEARCH,  32'h0000_0000);
      add_request(CMD_REMOVE,  32'h7FFF_FFFF);
      add_request(CMD_REMOVE,  32'h0000_0000);
      add_request(CMD_REMOVE,  32'hFFFF_FFFF);
      add_request(CMD_SEARCH,  32'hFFFF_FFFF);
      build_random_requests();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Every request sent, then every result back, then a short settle time.
      while (sent_count != request_total || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/ovl_pkg.sv
hw/rtl/ovl_cell.sv
hw/rtl/ordered_value_list.sv
test/ordered_value_list_tb.sv
